// File: hw/rtl/isort_pkg.sv
`default_nettype none

package isort_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } isort_state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                     insert;
    logic                     shift;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

  // What one cell shows to its neighbors.
  typedef struct packed {
    logic                     valid;
    logic                     gt;
    logic signed [DATA_W-1:0] value;
  } cell_view_t;

endpackage

`default_nettype wire

// File: hw/rtl/isort_if.sv
`default_nettype none

interface isort_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface isort_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_res;
  logic               last_res;
  logic               overflow;

  modport source (output valid, output value_res, output last_res, output overflow,
                  input ready);
  modport sink (input valid, input value_res, input last_res, input overflow,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/insertion_sorter.sv
// Words are accepted back to back while loading; each is inserted into the cell chain.
// Words past the chain capacity are dropped and flag every result of their run.
// After the last word of a run is accepted, the sorter enters its drain state and the
// first result is registered in the output register. Draining moves one word per cycle out
// of the chain while the output is not stalled; input is held off until the chain empties.
// Reset (synchronous, active low) empties the chain and the output register.
`default_nettype none

module insertion_sorter (
  input  wire logic  clk,
  input  wire logic  rst_n,
  isort_in_if.sink   in_ch,
  isort_out_if.source out_ch
);
  import isort_pkg::*;

  isort_state_t state_r;
  isort_state_t state_nxt;
  logic         ovf_r;
  logic         ovf_nxt;

  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r;
  logic signed [DATA_W-1:0] out_value_nxt;
  logic                     out_last_r;
  logic                     out_last_nxt;
  logic                     out_ovf_r;
  logic                     out_ovf_nxt;

  cell_cmd_t  cmd;
  cell_view_t views [CAPACITY];
  cell_view_t prevs [CAPACITY];
  cell_view_t nexts [CAPACITY];

  logic in_acc;
  logic full;
  logic pop;

  assign full   = views[CAPACITY-1].valid;
  assign in_acc = in_ch.valid && (state_r == ST_LOAD);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prevs[i] = '{valid: 1'b1, gt: 1'b0, value: '0};
    end else begin : g_body
      assign prevs[i] = views[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign nexts[i] = '{valid: 1'b0, gt: 1'b0, value: '0};
    end else begin : g_link
      assign nexts[i] = views[i+1];
    end

    isort_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .cmd  (cmd),
      .prev (prevs[i]),
      .next (nexts[i]),
      .self (views[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    pop           = 1'b0;
    in_ch.ready   = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_LOAD: begin
        in_ch.ready = 1'b1;
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!views[0].valid) begin
          state_nxt = ST_LOAD;
          ovf_nxt   = 1'b0;
        end else if (!out_valid_r || out_ch.ready) begin
          pop           = 1'b1;
          out_valid_nxt = 1'b1;
          out_value_nxt = views[0].value;
          out_last_nxt  = !views[1].valid;
          out_ovf_nxt   = ovf_r;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    cmd.insert = in_acc && !full;
    cmd.shift  = pop;
    cmd.value  = in_ch.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_res = out_value_r;
  assign out_ch.last_res  = out_last_r;
  assign out_ch.overflow  = out_ovf_r;

endmodule

`default_nettype wire

// File: hw/rtl/isort_cell.sv
`default_nettype none

module isort_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire isort_pkg::cell_cmd_t   cmd,
  input  wire isort_pkg::cell_view_t  prev,
  input  wire isort_pkg::cell_view_t  next,
  output isort_pkg::cell_view_t       self
);
  import isort_pkg::*;

  logic                     valid_r;
  logic                     valid_nxt;
  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;
  logic                     gt;

  // The new word goes ahead of this entry only if it is strictly smaller.
  assign gt = valid_r && (cmd.value < value_r);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (cmd.shift) begin
      valid_nxt = next.valid;
      value_nxt = next.value;
    end else if (cmd.insert) begin
      valid_nxt = valid_r | prev.valid;
      if (prev.gt) begin
        value_nxt = prev.value;
      end else if (gt || !valid_r) begin
        value_nxt = cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    value_r <= value_nxt;
  end

  assign self.valid = valid_r;
  assign self.gt    = gt;
  assign self.value = value_r;

endmodule

`default_nettype wire

// File: hw/rtl/isort_checker.sv
`default_nettype none

module isort_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value_res,
  input wire logic        out_last_res,
  input wire logic        out_overflow
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_res)
      && $stable(out_last_res) && $stable(out_overflow))
    else $error("stalled result word changed");

  // The last word of a run closes the input until the run has drained.
  a_run_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input open right after the end of a run");

  // No input is taken while a run is still being delivered.
  a_no_input_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_res |-> !in_ready)
    else $error("input open while a run is delivered");

  // Inside a run the results follow without gaps and keep one overflow flag.
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_res |=>
      out_valid && (out_overflow == $past(out_overflow)))
    else $error("gap or overflow change inside a run");

endmodule

bind insertion_sorter isort_checker u_isort_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_last      (in_ch.last),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_value_res(out_ch.value_res),
  .out_last_res (out_ch.last_res),
  .out_overflow (out_ch.overflow)
);

`default_nettype wire
